@@ rtl/bdts_pkg.sv @@
// Shared types, constants and helpers for the disjoint track selector.
`default_nettype none

package bdts_pkg;

    localparam int unsigned MAX_TRACKS_DEF         = 64;
    localparam int unsigned PLANES_DEF             = 6;
    localparam int unsigned CLUSTERS_PER_PLANE_DEF = 16;
    localparam int unsigned IN_PLANES              = 6;

    typedef struct packed {
        logic [31:0]                score;
        logic [IN_PLANES-1:0]       plane_mask;
        logic [3:0]                 cluster_p0;
        logic [3:0]                 cluster_p1;
        logic [3:0]                 cluster_p2;
        logic [3:0]                 cluster_p3;
        logic [3:0]                 cluster_p4;
        logic [3:0]                 cluster_p5;
        logic                       last_candidate;
    } in_req_t;

    typedef struct packed {
        logic [5:0]                 track_index;
        logic [31:0]                kept_score;
        logic [IN_PLANES-1:0]       kept_mask;
        logic                       last_kept;
        logic                       dropped;
    } out_req_t;

    // One stored candidate as it moves along the sorting chain.
    typedef struct packed {
        logic [31:0]                score;
        logic [IN_PLANES-1:0]       mask;
        logic [IN_PLANES-1:0][3:0]  clusters;
        logic [5:0]                 arrival;
    } entry_t;

    typedef struct packed {
        logic insert;
        logic shift;
    } cell_cmd_t;

    typedef enum logic {
        ST_LOAD,
        ST_SCAN
    } state_t;

    // Reduces a 4-bit cluster index modulo the number of clusters per plane.
    function automatic logic [3:0] clus_mod(input logic [3:0] v, input int unsigned m);
        logic [3:0] r;
        r = v;
        for (int k = 0; k < 8; k++) begin
            if ({28'd0, r} >= m) begin
                r = r - 4'(m);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/bdts_cell.sv @@
// One cell of the insertion sorting chain, holding a single candidate.
`default_nettype none

module bdts_cell
    import bdts_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    new_entry,
    input  wire entry_t    left_entry,
    input  wire logic      left_valid,
    input  wire logic      left_after,
    input  wire entry_t    right_entry,
    input  wire logic      right_valid,
    output entry_t         entry,
    output logic           valid,
    output logic           after
);

    entry_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    // Equal scores stay ahead of the newcomer, which keeps arrival order.
    assign after = valid_reg && (entry_reg.score <= new_entry.score);

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (cmd.insert && !after) begin
            if (left_after) begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end else begin
                entry_next = left_entry;
                valid_next = left_valid;
            end
        end else if (cmd.shift) begin
            entry_next = right_entry;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

@@ rtl/bdts_claim.sv @@
// Per-plane used-cluster bitmaps with clash check and claim.
`default_nettype none

module bdts_claim
    import bdts_pkg::*;
#(
    parameter int unsigned PLANES             = PLANES_DEF,
    parameter int unsigned CLUSTERS_PER_PLANE = CLUSTERS_PER_PLANE_DEF
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire entry_t head,
    input  wire logic   claim,
    input  wire logic   clear,
    output logic        clash
);

    localparam int unsigned NP     = (PLANES < IN_PLANES) ? PLANES : IN_PLANES;
    localparam int unsigned CIDX_W = $clog2(CLUSTERS_PER_PLANE);

    logic [PLANES-1:0][CLUSTERS_PER_PLANE-1:0] used_reg, used_next;
    logic [NP-1:0][CIDX_W-1:0]                 idx;

    always_comb
    begin
        for (int p = 0; p < NP; p++) begin
            idx[p] = CIDX_W'(clus_mod(head.clusters[p], CLUSTERS_PER_PLANE));
        end
    end

    always_comb
    begin
        clash = 1'b0;
        for (int p = 0; p < NP; p++) begin
            if (head.mask[p] && used_reg[p][idx[p]]) begin
                clash = 1'b1;
            end
        end
    end

    always_comb
    begin
        used_next = used_reg;
        if (clear) begin
            used_next = '0;
        end else if (claim) begin
            for (int p = 0; p < NP; p++) begin
                if (head.mask[p]) begin
                    used_next[p][idx[p]] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            used_reg <= '0;
        end else begin
            used_reg <= used_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/best_score_disjoint_track_select.sv @@
// Top level of the greedy best-score disjoint track selector.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------
//  in      | request in | in_valid/in_stall  | in_req  (score, mask, clusters)
//  out     | request out| out_valid/out_stall| out_req (index, score, mask)
//
// While loading, one request is taken every cycle; each of the first
// MAX_TRACKS goes into its sorted place in a chain of MAX_TRACKS cells and
// later ones only set the dropped flag, so loading never stalls. After the
// request marked last, the chain drains from its head at one candidate per
// cycle unless the output holds it: N scan steps for N stored candidates
// and one closing step, before new requests are taken again.
// Reset is asynchronous and active low; it empties the chain and clears
// the cluster bitmaps. A stalled output holds the scan when a kept candidate
// must be passed on, and holds the closing step; rejected ones keep draining.

`default_nettype none

module best_score_disjoint_track_select
    import bdts_pkg::*;
#(
    parameter int unsigned MAX_TRACKS         = MAX_TRACKS_DEF,
    parameter int unsigned PLANES             = PLANES_DEF,
    parameter int unsigned CLUSTERS_PER_PLANE = CLUSTERS_PER_PLANE_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_stall,
    input  wire in_req_t in_req,
    output logic         out_valid,
    input  wire logic    out_stall,
    output out_req_t     out_req
);

    localparam int unsigned CNT_W = $clog2(MAX_TRACKS + 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             overflow_reg, overflow_next;
    logic             pend_valid_reg, pend_valid_next;
    entry_t           pend_reg, pend_next;
    logic             out_valid_reg, out_valid_next;
    out_req_t         out_reg, out_next;

    logic      in_acc;
    logic      insert;
    logic      out_free;
    logic      kept;
    logic      step;
    logic      finish;
    logic      clash;
    cell_cmd_t cmd;
    entry_t    new_entry;

    entry_t cell_entry [MAX_TRACKS];
    logic   cell_valid [MAX_TRACKS];
    logic   cell_after [MAX_TRACKS];

    // The new candidate, with its clusters packed by plane.
    always_comb
    begin
        new_entry.score       = in_req.score;
        new_entry.mask        = in_req.plane_mask;
        new_entry.clusters[0] = in_req.cluster_p0;
        new_entry.clusters[1] = in_req.cluster_p1;
        new_entry.clusters[2] = in_req.cluster_p2;
        new_entry.clusters[3] = in_req.cluster_p3;
        new_entry.clusters[4] = in_req.cluster_p4;
        new_entry.clusters[5] = in_req.cluster_p5;
        new_entry.arrival     = 6'(count_reg);
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        in_stall = (state_reg != ST_LOAD);
        in_acc   = in_valid && !in_stall;
        insert   = in_acc && (count_reg < CNT_W'(MAX_TRACKS));
        out_free = !out_valid_reg || !out_stall;
        kept     = cell_valid[0] && !clash;
        step     = (state_reg == ST_SCAN) && cell_valid[0]
                   && (!kept || !pend_valid_reg || out_free);
        finish   = (state_reg == ST_SCAN) && !cell_valid[0] && out_free;
        cmd.insert = insert;
        cmd.shift  = step;
    end

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (in_acc && in_req.last_candidate) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (finish) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TRACKS; gi++) begin : g_cell
            entry_t le, re;
            logic   lv, la, rv;
            if (gi == 0) begin : g_head
                assign le = new_entry;
                assign lv = 1'b0;
                assign la = 1'b1;
            end else begin : g_mid
                assign le = cell_entry[gi-1];
                assign lv = cell_valid[gi-1];
                assign la = cell_after[gi-1];
            end
            if (gi == MAX_TRACKS - 1) begin : g_tail
                assign re = new_entry;
                assign rv = 1'b0;
            end else begin : g_body
                assign re = cell_entry[gi+1];
                assign rv = cell_valid[gi+1];
            end
            bdts_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .new_entry   (new_entry),
                .left_entry  (le),
                .left_valid  (lv),
                .left_after  (la),
                .right_entry (re),
                .right_valid (rv),
                .entry       (cell_entry[gi]),
                .valid       (cell_valid[gi]),
                .after       (cell_after[gi])
            );
        end
    endgenerate

    bdts_claim #(
        .PLANES             (PLANES),
        .CLUSTERS_PER_PLANE (CLUSTERS_PER_PLANE)
    ) u_claim (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (cell_entry[0]),
        .claim (step && kept),
        .clear (finish),
        .clash (clash)
    );

    // A kept candidate waits in the pending register until the next kept
    // one shows up or the chain runs empty; only then is it known whether
    // it is the final result of the set.
    always_comb
    begin
        count_next      = count_reg;
        overflow_next   = overflow_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_next        = out_reg;

        if (insert) begin
            count_next = count_reg + 1'b1;
        end else if (in_acc) begin
            overflow_next = 1'b1;
        end

        if (step && kept) begin
            pend_next       = cell_entry[0];
            pend_valid_next = 1'b1;
        end

        if ((step && kept && pend_valid_reg) || (finish && pend_valid_reg)) begin
            out_valid_next       = 1'b1;
            out_next.track_index = pend_reg.arrival;
            out_next.kept_score  = pend_reg.score;
            out_next.kept_mask   = pend_reg.mask;
            out_next.last_kept   = finish;
            out_next.dropped     = overflow_reg;
        end

        if (finish) begin
            pend_valid_next = 1'b0;
            count_next      = '0;
            overflow_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg      <= ST_LOAD;
            count_reg      <= '0;
            overflow_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            overflow_reg   <= overflow_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_req   = out_reg;

endmodule

`default_nettype wire

@@ rtl/bdts_checker.sv @@
// Port-level checks for the track selector and their binding.
`default_nettype none

module bdts_checker
    import bdts_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_stall,
    input wire in_req_t  in_req,
    input wire logic     out_valid,
    input wire logic     out_stall,
    input wire out_req_t out_req
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its contents.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_req))
        else $error("result changed while stalled");

    // The final request of a set starts selection, which blocks new requests.
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_req.last_candidate |=> in_stall)
        else $error("request taken right after the last of a set");

endmodule

bind best_score_disjoint_track_select bdts_checker u_bdts_checker (.*);

`default_nettype wire
